[hw/rtl/color_bar_test_pattern_unit_defines.svh]
// Assertion macros shared by the color bar test pattern RTL.
`ifndef COLOR_BAR_TEST_PATTERN_UNIT_DEFINES_SVH
`define COLOR_BAR_TEST_PATTERN_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CBTP_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication
`define CBTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define CBTP_ASSERT(lbl, clk, rst_n, ante, cons)
`define CBTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/cbtp_pkg.sv]
// Types, constants and tables of the color bar test pattern unit.
package cbtp_pkg;

  localparam int unsigned MAX_DIM_DEF = 4096;

  localparam int unsigned DIM_W  = 13;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned REM_W  = 20;
  localparam int unsigned QUO_W  = 8;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHROMA_FORMAT = 2'd2;

  localparam logic [7:0] RAMP_SPAN    = 8'd220;
  localparam logic [7:0] RAMP_BASE    = 8'd16;
  localparam logic [7:0] CHROMA_FLAT  = 8'd128;

  localparam logic [7:0] BAR_LUMA [8] = '{8'd235, 8'd210, 8'd170, 8'd145,
                                          8'd106, 8'd81,  8'd41,  8'd16};
  localparam logic [7:0] BAR_CB   [8] = '{8'd128, 8'd16,  8'd166, 8'd54,
                                          8'd202, 8'd90,  8'd240, 8'd128};
  localparam logic [7:0] BAR_CR   [8] = '{8'd128, 8'd146, 8'd16,  8'd34,
                                          8'd222, 8'd240, 8'd110, 8'd128};

  typedef enum logic [2:0] {
    K_ZERO    = 3'd0,
    K_LUMA    = 3'd1,
    K_CB      = 3'd2,
    K_CR      = 3'd3,
    K_RAMP    = 3'd4,
    K_FLAT    = 3'd5,
    K_NEUTRAL = 3'd6
  } kind_t;

  // frame geometry derived from the registers
  typedef struct packed {
    logic [DIM_W-1:0]        w;
    logic [DIM_W-1:0]        h;
    logic [DIM_W-1:0]        bars_h;
    logic [DIM_W-1:0]        crows;
    logic [DIM_W-1:0]        wm1;
    logic                    w_gt1;
    logic                    fmt;
    logic [7:1][THR_W-1:0]   thr;
  } geom_t;

  typedef struct packed {
    logic        in_plane;
    kind_t       kind;
    logic [2:0]  bar;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [REM_W-1:0]   rem;
    logic [DIM_W-1:0]   dvs;
    logic [QUO_W-1:0]   quo;
  } div_t;

endpackage

[hw/rtl/cbtp_regs.sv]
// Configuration registers, APB access and derived frame geometry.
`include "color_bar_test_pattern_unit_defines.svh"
module cbtp_regs #(
  parameter int unsigned MAX_DIM = cbtp_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbtp_pkg::ADDR_W-1:0]    paddr,
  input  logic [cbtp_pkg::DATA_W-1:0]    pwdata,
  output logic [cbtp_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output cbtp_pkg::geom_t                geom,
  output logic                           busy
);

  logic [cbtp_pkg::DIM_W-1:0] frame_width_r;
  logic [cbtp_pkg::DIM_W-1:0] frame_height_r;
  logic                       chroma_format_r;
  cbtp_pkg::geom_t            geom_r;
  cbtp_pkg::geom_t            geom_nxt;
  logic                       busy_r;
  logic                       wr_en;
  logic [cbtp_pkg::DIM_W-1:0] w_c;
  logic [cbtp_pkg::DIM_W-1:0] h_c;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= cbtp_pkg::FRAME_WIDTH_RST;
      frame_height_r  <= cbtp_pkg::FRAME_HEIGHT_RST;
      chroma_format_r <= 1'b0;
    end else if (wr_en) begin
      case (paddr[3:2])
        cbtp_pkg::REG_FRAME_WIDTH:   frame_width_r   <= pwdata[cbtp_pkg::DIM_W-1:0];
        cbtp_pkg::REG_FRAME_HEIGHT:  frame_height_r  <= pwdata[cbtp_pkg::DIM_W-1:0];
        cbtp_pkg::REG_CHROMA_FORMAT: chroma_format_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cbtp_pkg::REG_FRAME_WIDTH:   prdata = 32'(frame_width_r);
      cbtp_pkg::REG_FRAME_HEIGHT:  prdata = 32'(frame_height_r);
      cbtp_pkg::REG_CHROMA_FORMAT: prdata = 32'(chroma_format_r);
      default:                     prdata = '0;
    endcase
  end

  // clamp to the largest supported dimension
  assign w_c = (17'(frame_width_r) > 17'(MAX_DIM)) ?
               cbtp_pkg::DIM_W'(MAX_DIM) : frame_width_r;
  assign h_c = (17'(frame_height_r) > 17'(MAX_DIM)) ?
               cbtp_pkg::DIM_W'(MAX_DIM) : frame_height_r;

  always_comb begin
    geom_nxt.w      = w_c;
    geom_nxt.h      = h_c;
    geom_nxt.bars_h = h_c - (h_c >> 2);
    geom_nxt.crows  = chroma_format_r ? h_c : (h_c >> 1);
    geom_nxt.wm1    = w_c - 13'd1;
    geom_nxt.w_gt1  = (w_c > 13'd1);
    geom_nxt.fmt    = chroma_format_r;
    // bar boundaries k*w, compared against col*8
    for (int k = 1; k <= 7; k++) begin
      geom_nxt.thr[k] = cbtp_pkg::THR_W'(k) * cbtp_pkg::THR_W'(w_c);
    end
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  // busy is set after reset and after each write, until the registered geometry settles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= wr_en;
    end
  end

  assign geom = geom_r;
  assign busy = busy_r;

  `CBTP_ASSERT_NEXT(a_write_sets_busy, clk, rst_n, wr_en, busy_r)

endmodule

[hw/rtl/cbtp_classify.sv]
// Input register and classification stage: plane bounds, bar index, ramp dividend.
module cbtp_classify (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cbtp_pkg::geom_t             geom,
  input  logic                        hold,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [cbtp_pkg::IDX_W-1:0]  in_line_index,
  input  logic [cbtp_pkg::IDX_W-1:0]  in_byte_index,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output cbtp_pkg::div_t              dn_data
);

  logic                       s1_v_r;
  logic                       s1_plane_r;
  logic [cbtp_pkg::IDX_W-1:0] s1_row_r;
  logic [cbtp_pkg::IDX_W-1:0] s1_col_r;
  logic                       s2_v_r;
  cbtp_pkg::div_t             s2_r;
  cbtp_pkg::div_t             s2_nxt;
  logic                       rdy1;
  logic                       rdy2;
  logic                       accept;

  logic [cbtp_pkg::THR_W-1:0] col8;
  logic [7:1]                 therm;
  logic [2:0]                 bar;
  logic [cbtp_pkg::DIM_W-1:0] row_lim;
  logic [cbtp_pkg::DIM_W-1:0] lrow;
  logic                       in_plane;
  logic                       in_bars;
  cbtp_pkg::kind_t            kind;

  assign rdy2     = !s2_v_r || dn_ready;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1 && !hold;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_plane_r <= in_req_type;
      s1_row_r   <= in_line_index;
      s1_col_r   <= in_byte_index;
    end
  end

  always_comb begin
    // chroma pairs take the bar of their even column
    col8 = s1_plane_r ? cbtp_pkg::THR_W'({s1_col_r[11:1], 1'b0, 3'b000}) :
                        cbtp_pkg::THR_W'({s1_col_r, 3'b000});
    for (int k = 1; k <= 7; k++) begin
      therm[k] = (col8 >= geom.thr[k]);
    end
    bar = 3'd0;
    for (int k = 1; k <= 7; k++) begin
      bar = bar + 3'(therm[k]);
    end

    row_lim  = s1_plane_r ? geom.crows : geom.h;
    in_plane = ({1'b0, s1_row_r} < row_lim) && ({1'b0, s1_col_r} < geom.w);
    // NV12 chroma row r lands on luma row 2r, NV16 on r
    if (s1_plane_r && !geom.fmt) begin
      lrow = {s1_row_r, 1'b0};
    end else begin
      lrow = {1'b0, s1_row_r};
    end
    in_bars = (lrow < geom.bars_h);

    if (!in_plane) begin
      kind = cbtp_pkg::K_ZERO;
    end else if (!s1_plane_r) begin
      if (in_bars) begin
        kind = cbtp_pkg::K_LUMA;
      end else if (geom.w_gt1) begin
        kind = cbtp_pkg::K_RAMP;
      end else begin
        kind = cbtp_pkg::K_FLAT;
      end
    end else if (in_bars) begin
      kind = s1_col_r[0] ? cbtp_pkg::K_CR : cbtp_pkg::K_CB;
    end else begin
      kind = cbtp_pkg::K_NEUTRAL;
    end

    s2_nxt.side.in_plane = in_plane;
    s2_nxt.side.kind     = kind;
    s2_nxt.side.bar      = bar;
    s2_nxt.rem = cbtp_pkg::REM_W'(s1_col_r) * cbtp_pkg::REM_W'(cbtp_pkg::RAMP_SPAN);
    s2_nxt.dvs = geom.wm1;
    s2_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign dn_valid = s2_v_r;
  assign dn_data  = s2_r;

endmodule

[hw/rtl/cbtp_ramp_div.sv]
// Pipelined restoring divider for the ramp, one quotient bit per stage.
`include "color_bar_test_pattern_unit_defines.svh"
module cbtp_ramp_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  cbtp_pkg::div_t   up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output cbtp_pkg::div_t   dn_data
);

  localparam int unsigned N = cbtp_pkg::DIV_STEPS;

  logic             st_v_r [N];
  cbtp_pkg::div_t   st_r   [N];
  logic [N:0]       rdy;

  function automatic cbtp_pkg::div_t div_step(cbtp_pkg::div_t s, int unsigned bitpos);
    logic [cbtp_pkg::REM_W-1:0] trial;
    cbtp_pkg::div_t             r;
    trial = cbtp_pkg::REM_W'(s.dvs) << bitpos;
    r     = s;
    if (s.rem >= trial) begin
      r.rem = s.rem - trial;
      r.quo = s.quo | (cbtp_pkg::QUO_W'(1) << bitpos);
    end
    return r;
  endfunction

  always_comb begin
    rdy[N] = dn_ready;
    for (int j = N - 1; j >= 0; j--) begin
      rdy[j] = !st_v_r[j] || rdy[j+1];
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic           prev_v;
    cbtp_pkg::div_t prev_d;
    if (j == 0) begin : g_first
      assign prev_v = up_valid;
      assign prev_d = up_data;
    end else begin : g_rest
      assign prev_v = st_v_r[j-1];
      assign prev_d = st_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        st_v_r[j] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && prev_v) begin
        st_r[j] <= div_step(prev_d, N - 1 - j);
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = st_v_r[N-1];
  assign dn_data  = st_r[N-1];

  `CBTP_ASSERT(a_ramp_in_range, clk, rst_n,
               dn_valid && (dn_data.side.kind == cbtp_pkg::K_RAMP),
               dn_data.quo <= cbtp_pkg::RAMP_SPAN)

endmodule

[hw/rtl/color_bar_test_pattern_unit.sv]
// Color bar test pattern unit: NV12/NV16 test frame byte lookup, top level.
// Each item passes the input, classify, 8 ramp divider and output registers in order.
// Throughput: one item per cycle unless out_ready is low or busy holds off the input.
// A stalled output does not block entry while earlier stages hold bubbles.
// Reset: synchronous, active low; registers take 640x480 NV12, pipeline empties.
// Input is held off after reset and after each register write until the geometry settles.
`include "color_bar_test_pattern_unit_defines.svh"
module color_bar_test_pattern_unit #(
  parameter int unsigned MAX_DIM = cbtp_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbtp_pkg::ADDR_W-1:0]  paddr,
  input  logic [cbtp_pkg::DATA_W-1:0]  pwdata,
  output logic [cbtp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [cbtp_pkg::IDX_W-1:0]   in_line_index,
  input  logic [cbtp_pkg::IDX_W-1:0]   in_byte_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_pixel_value,
  output logic                         out_in_frame
);

  cbtp_pkg::geom_t geom;
  logic            busy;
  logic            cl_valid;
  logic            cl_ready;
  cbtp_pkg::div_t  cl_data;
  logic            dv_valid;
  logic            dv_ready;
  cbtp_pkg::div_t  dv_data;

  logic            out_valid_r;
  logic [7:0]      out_pixel_value_r;
  logic [7:0]      out_pixel_value_nxt;
  logic            out_in_frame_r;

  cbtp_regs #(
    .MAX_DIM(MAX_DIM)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom),
    .busy    (busy)
  );

  cbtp_classify u_classify (
    .clk           (clk),
    .rst_n         (rst_n),
    .geom          (geom),
    .hold          (busy),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_line_index (in_line_index),
    .in_byte_index (in_byte_index),
    .dn_valid      (cl_valid),
    .dn_ready      (cl_ready),
    .dn_data       (cl_data)
  );

  cbtp_ramp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cl_valid),
    .up_ready (cl_ready),
    .up_data  (cl_data),
    .dn_valid (dv_valid),
    .dn_ready (dv_ready),
    .dn_data  (dv_data)
  );

  assign dv_ready = !out_valid_r || out_ready;

  always_comb begin
    case (dv_data.side.kind)
      cbtp_pkg::K_LUMA:    out_pixel_value_nxt = cbtp_pkg::BAR_LUMA[dv_data.side.bar];
      cbtp_pkg::K_CB:      out_pixel_value_nxt = cbtp_pkg::BAR_CB[dv_data.side.bar];
      cbtp_pkg::K_CR:      out_pixel_value_nxt = cbtp_pkg::BAR_CR[dv_data.side.bar];
      cbtp_pkg::K_RAMP:    out_pixel_value_nxt = cbtp_pkg::RAMP_BASE + dv_data.quo;
      cbtp_pkg::K_FLAT:    out_pixel_value_nxt = cbtp_pkg::RAMP_BASE;
      cbtp_pkg::K_NEUTRAL: out_pixel_value_nxt = cbtp_pkg::CHROMA_FLAT;
      default:             out_pixel_value_nxt = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dv_ready) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready && dv_valid) begin
      out_pixel_value_r <= out_pixel_value_nxt;
      out_in_frame_r    <= dv_data.side.in_plane;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pixel_value_r;
  assign out_in_frame    = out_in_frame_r;

  `CBTP_ASSERT(a_outside_is_zero, clk, rst_n,
               out_valid_r && !out_in_frame_r, out_pixel_value_r == 8'd0)
  `CBTP_ASSERT(a_no_entry_while_busy, clk, rst_n, busy, !in_ready)
  `CBTP_ASSERT(a_inside_kind, clk, rst_n,
               dv_valid && (dv_data.side.kind == cbtp_pkg::K_ZERO), !dv_data.side.in_plane)

endmodule
